// File: rtl/htach_pkg.sv
package htach_pkg;

    // Averaging ring
    localparam int AVG_DEPTH = 8;
    localparam int AVG_IDX_W = $clog2(AVG_DEPTH);
    localparam int RPM_W     = 16;
    localparam int SUM_W     = RPM_W + AVG_IDX_W;

    // Field widths
    localparam int SAMPLE_W  = 10;
    localparam int TIME_W    = 32;
    localparam int SPEED_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Divider: quotient of a 16-bit constant by interval * magnets
    localparam int DEN_W     = 24;
    localparam int DIV_STEPS = RPM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int MUL_W     = 16;
    localparam int PROD_W    = 2 * MUL_W;

    localparam logic [SAMPLE_W-1:0] MIDPOINT      = 10'd512;
    localparam logic [RPM_W-1:0]    RPM_NUMERATOR = 16'd60000;
    localparam logic [RPM_W-1:0]    PASS_MAX      = 16'hFFFF;
    localparam logic [SPEED_W-1:0]  SPEED_MAX     = 8'd255;

    // Register reset values
    localparam logic [7:0]  RST_HYSTERESIS   = 8'd20;
    localparam logic [7:0]  RST_MAGNET_COUNT = 8'd8;
    localparam logic [15:0] RST_MAX_INTERVAL = 16'd300;
    localparam logic [15:0] RST_BCAST_PERIOD = 16'd50;
    localparam logic [7:0]  RST_STOP_PERIODS = 8'd10;
    localparam logic [15:0] RST_SPEED_FACTOR = 16'd1359;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HYSTERESIS   = 3'd0,
        REG_MAGNET_COUNT = 3'd1,
        REG_MAX_INTERVAL = 3'd2,
        REG_BCAST_PERIOD = 3'd3,
        REG_STOP_PERIODS = 3'd4,
        REG_SPEED_FACTOR = 3'd5
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PERIOD,
        S_EDGE,
        S_DIV,
        S_PUSH,
        S_SPEED,
        S_DONE
    } t_state;

endpackage

// File: rtl/hall_tachometer_with_stop_detect.sv
// Hall-sensor tachometer with stop detection.
//
// Input channel (i_valid / o_ready): one item is one poll, a 10-bit Hall
// sample and a millisecond timestamp. Output channel (o_valid / i_ready):
// exactly one result item per input item, in order: edge flag, pass rpm,
// ring average rpm, speed in km/h and broadcast flag.
// Configuration is a plain write port (i_cfg_wr_en, i_cfg_index,
// i_cfg_wdata), taken at any edge with the enable high; write it only
// while the block is idle. Indexes beyond the register list are dropped.
// Steps: an item passes period, edge, speed and done; one with a magnet
// pass adds the divider and a ring push after edge (just the push when the
// interval is too long for an rpm). o_ready is high only in the idle state,
// entered from done as it registers the result. The 16-step restoring
// divider dominates, one quotient bit per cycle. One 16x16 multiplier
// serves both the divisor (interval * magnets) and the speed scaling.
// A finished result sits in the output register, so the next item is
// accepted while it waits; that next item then holds in its last step
// until the receiver takes the pending result.
// Reset (synchronous, active low) restores register defaults, clears the
// rpm ring, the timers and counters, and empties the output register.
module hall_tachometer_with_stop_detect (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    // input items
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [9:0]  i_sample,
    input  logic [31:0] i_now_ms,
    // result items
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_edge_seen,
    output logic [15:0] o_pass_rpm,
    output logic [15:0] o_average_rpm,
    output logic [7:0]  o_speed_kmh,
    output logic        o_broadcast
);

    // Configuration registers
    logic [7:0]  r_hyst;
    logic [7:0]  r_magnets;
    logic [15:0] r_max_int;
    logic [15:0] r_bperiod;
    logic [7:0]  r_stop_periods;
    logic [15:0] r_speed_factor;

    // Tracking state
    logic                                   r_sensor_high;
    logic [htach_pkg::TIME_W-1:0]           r_last_high;
    logic [htach_pkg::TIME_W-1:0]           r_last_low;
    logic [htach_pkg::RPM_W-1:0]            r_ring [htach_pkg::AVG_DEPTH];
    logic [htach_pkg::AVG_IDX_W-1:0]        r_ring_idx;
    logic [htach_pkg::SUM_W-1:0]            r_ring_sum;
    logic [15:0]                            r_passes;
    logic [7:0]                             r_idle;
    logic [htach_pkg::TIME_W-1:0]           r_period_start;
    logic [htach_pkg::RPM_W-1:0]            r_last_pass;

    // Item work registers
    htach_pkg::t_state                      r_state;
    htach_pkg::t_state                      n_state;
    logic [htach_pkg::SAMPLE_W-1:0]         r_sample;
    logic [htach_pkg::TIME_W-1:0]           r_now;
    logic                                   r_edge;
    logic                                   r_bcast;
    logic [htach_pkg::DEN_W-1:0]            r_den;
    logic [htach_pkg::DEN_W-1:0]            r_rem;
    logic [htach_pkg::RPM_W-1:0]            r_quo;
    logic [htach_pkg::DIV_CNT_W-1:0]        r_cnt;
    logic [htach_pkg::PROD_W-1:0]           r_prod;
    logic [htach_pkg::RPM_W-1:0]            r_avg;

    // Combinational datapath
    logic [htach_pkg::TIME_W-1:0]   w_elapsed;
    logic                           w_bcast_hit;
    logic [htach_pkg::SAMPLE_W-1:0] w_thr_lo;
    logic [htach_pkg::SAMPLE_W-1:0] w_thr_hi;
    logic                           w_edge_hit;
    logic [htach_pkg::TIME_W-1:0]   w_interval_raw;
    logic [htach_pkg::TIME_W-1:0]   w_interval;
    logic                           w_too_long;
    logic [7:0]                     w_mags;
    logic [htach_pkg::MUL_W-1:0]    w_mul_a;
    logic [htach_pkg::MUL_W-1:0]    w_mul_b;
    logic [htach_pkg::PROD_W-1:0]   w_mul_p;
    logic [htach_pkg::DEN_W:0]      w_rem_sh;
    logic                           w_div_ge;
    logic [htach_pkg::DEN_W:0]      w_rem_diff;
    logic                           w_push_en;
    logic [htach_pkg::RPM_W-1:0]    w_push_val;
    logic                           w_out_free;
    logic [htach_pkg::SPEED_W-1:0]  w_speed;

    assign o_ready    = (r_state == htach_pkg::S_IDLE);
    assign w_out_free = !o_valid || i_ready;

    // Broadcast period check, modulo 2^32 time
    assign w_elapsed   = r_now - r_period_start;
    assign w_bcast_hit = w_elapsed >= {16'd0, r_bperiod};

    // Hysteresis thresholds stay inside 257..767 for any 8-bit setting
    assign w_thr_lo   = htach_pkg::MIDPOINT - {2'd0, r_hyst};
    assign w_thr_hi   = htach_pkg::MIDPOINT + {2'd0, r_hyst};
    assign w_edge_hit = r_sensor_high ? (r_sample < w_thr_lo) : (r_sample > w_thr_hi);

    // Interval since the opposite edge; zero counts as one millisecond
    assign w_interval_raw = r_now - (r_sensor_high ? r_last_high : r_last_low);
    assign w_interval     = (w_interval_raw == '0) ? 32'd1 : w_interval_raw;
    assign w_too_long     = w_interval > {16'd0, r_max_int};
    assign w_mags         = (r_magnets == 8'd0) ? 8'd1 : r_magnets;

    // Shared multiplier: divisor in the edge step, speed scaling later
    always_comb begin
        if (r_state == htach_pkg::S_SPEED) begin
            w_mul_a = r_ring_sum[htach_pkg::SUM_W-1:htach_pkg::AVG_IDX_W];
            w_mul_b = r_speed_factor;
        end else begin
            w_mul_a = w_interval[htach_pkg::MUL_W-1:0];
            w_mul_b = {8'd0, w_mags};
        end
    end
    assign w_mul_p = w_mul_a * w_mul_b;

    // One restoring divider step
    assign w_rem_sh   = {r_rem, r_quo[htach_pkg::RPM_W-1]};
    assign w_div_ge   = w_rem_sh >= {1'b0, r_den};
    assign w_rem_diff = w_rem_sh - {1'b0, r_den};

    // Ring push: a zero on a stopped period, or the pass rpm after an edge
    always_comb begin
        w_push_en  = 1'b0;
        w_push_val = '0;
        if (r_state == htach_pkg::S_PERIOD) begin
            w_push_en = w_bcast_hit && (r_passes == 16'd0) && !(r_idle < r_stop_periods);
        end else if (r_state == htach_pkg::S_PUSH) begin
            w_push_en  = 1'b1;
            w_push_val = r_quo;
        end
    end

    assign w_speed = (r_prod[31:24] != 8'd0) ? htach_pkg::SPEED_MAX : r_prod[23:16];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hyst         <= htach_pkg::RST_HYSTERESIS;
            r_magnets      <= htach_pkg::RST_MAGNET_COUNT;
            r_max_int      <= htach_pkg::RST_MAX_INTERVAL;
            r_bperiod      <= htach_pkg::RST_BCAST_PERIOD;
            r_stop_periods <= htach_pkg::RST_STOP_PERIODS;
            r_speed_factor <= htach_pkg::RST_SPEED_FACTOR;
        end else if (i_cfg_wr_en) begin
            unique case (htach_pkg::t_cfg_reg'(i_cfg_index))
                htach_pkg::REG_HYSTERESIS:   r_hyst         <= i_cfg_wdata[7:0];
                htach_pkg::REG_MAGNET_COUNT: r_magnets      <= i_cfg_wdata[7:0];
                htach_pkg::REG_MAX_INTERVAL: r_max_int      <= i_cfg_wdata;
                htach_pkg::REG_BCAST_PERIOD: r_bperiod      <= i_cfg_wdata;
                htach_pkg::REG_STOP_PERIODS: r_stop_periods <= i_cfg_wdata[7:0];
                htach_pkg::REG_SPEED_FACTOR: r_speed_factor <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= htach_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            htach_pkg::S_IDLE:   if (i_valid) n_state = htach_pkg::S_PERIOD;
            htach_pkg::S_PERIOD: n_state = htach_pkg::S_EDGE;
            htach_pkg::S_EDGE: begin
                if (!w_edge_hit) begin
                    n_state = htach_pkg::S_SPEED;
                end else if (w_too_long) begin
                    n_state = htach_pkg::S_PUSH;
                end else begin
                    n_state = htach_pkg::S_DIV;
                end
            end
            htach_pkg::S_DIV: begin
                if (r_cnt == htach_pkg::DIV_CNT_W'(htach_pkg::DIV_STEPS - 1)) begin
                    n_state = htach_pkg::S_PUSH;
                end
            end
            htach_pkg::S_PUSH:  n_state = htach_pkg::S_SPEED;
            htach_pkg::S_SPEED: n_state = htach_pkg::S_DONE;
            htach_pkg::S_DONE:  if (w_out_free) n_state = htach_pkg::S_IDLE;
            default:            n_state = htach_pkg::S_IDLE;
        endcase
    end

    // Tracking state and ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_high  <= 1'b0;
            r_last_high    <= '0;
            r_last_low     <= '0;
            r_ring_idx     <= '0;
            r_ring_sum     <= '0;
            r_passes       <= '0;
            r_idle         <= '0;
            r_period_start <= '0;
            r_last_pass    <= '0;
            for (int i = 0; i < htach_pkg::AVG_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
        end else begin
            if (w_push_en) begin
                r_ring[r_ring_idx] <= w_push_val;
                r_ring_sum <= r_ring_sum - htach_pkg::SUM_W'(r_ring[r_ring_idx])
                              + htach_pkg::SUM_W'(w_push_val);
                r_ring_idx <= r_ring_idx + 1'b1;
            end
            if (r_state == htach_pkg::S_PERIOD && w_bcast_hit) begin
                // Count idle periods up to the limit; a busy period clears it
                if (r_passes == 16'd0) begin
                    if (r_idle < r_stop_periods) begin
                        r_idle <= r_idle + 8'd1;
                    end
                end else begin
                    r_idle <= '0;
                end
                r_passes       <= '0;
                r_period_start <= r_now;
            end
            if (r_state == htach_pkg::S_EDGE && w_edge_hit) begin
                r_sensor_high <= !r_sensor_high;
                if (r_sensor_high) begin
                    r_last_low <= r_now;
                end else begin
                    r_last_high <= r_now;
                end
                if (r_passes != htach_pkg::PASS_MAX) begin
                    r_passes <= r_passes + 16'd1;
                end
                r_idle <= '0;
            end
            if (r_state == htach_pkg::S_PUSH) begin
                r_last_pass <= r_quo;
            end
        end
    end

    // Item datapath: capture, divider and speed product
    always_ff @(posedge i_clk) begin
        if (r_state == htach_pkg::S_IDLE && i_valid) begin
            r_sample <= i_sample;
            r_now    <= i_now_ms;
        end
        if (r_state == htach_pkg::S_PERIOD) begin
            r_bcast <= w_bcast_hit;
            r_edge  <= 1'b0;
        end
        if (r_state == htach_pkg::S_EDGE) begin
            r_edge <= w_edge_hit;
            r_den  <= w_mul_p[htach_pkg::DEN_W-1:0];
            r_rem  <= '0;
            r_cnt  <= '0;
            // A too-long interval skips the divider with a zero rpm
            r_quo  <= w_too_long ? '0 : htach_pkg::RPM_NUMERATOR;
        end
        if (r_state == htach_pkg::S_DIV) begin
            r_rem <= w_div_ge ? w_rem_diff[htach_pkg::DEN_W-1:0]
                              : w_rem_sh[htach_pkg::DEN_W-1:0];
            r_quo <= {r_quo[htach_pkg::RPM_W-2:0], w_div_ge};
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_state == htach_pkg::S_SPEED) begin
            r_prod <= w_mul_p;
            r_avg  <= w_mul_a;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (r_state == htach_pkg::S_DONE && w_out_free) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == htach_pkg::S_DONE && w_out_free) begin
            o_edge_seen   <= r_edge;
            o_pass_rpm    <= r_last_pass;
            o_average_rpm <= r_avg;
            o_speed_kmh   <= w_speed;
            o_broadcast   <= r_bcast;
        end
    end

    // Checks
    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted while an item is in progress");

    a_divisor_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == htach_pkg::S_DIV) |-> (r_den != '0))
        else $error("divider running with a zero divisor");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == htach_pkg::S_DONE))
        else $error("result raised outside the final step");

    a_no_pending_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready && r_state == htach_pkg::S_DONE) |=>
            (r_state == htach_pkg::S_DONE) && $stable(o_pass_rpm))
        else $error("pending result overwritten while stalled");

endmodule

// File: bench/hall_tachometer_with_stop_detect_tb.sv
module hall_tachometer_with_stop_detect_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Abort well beyond the slowest legal run.
    localparam int CYCLE_LIMIT = 600000;
    // Unused register slots; writes there must be dropped.
    localparam logic [htach_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [htach_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [htach_pkg::SAMPLE_W-1:0] sample;
        logic [htach_pkg::TIME_W-1:0]   now_ms;
    } t_poll;

    typedef struct packed {
        logic                          edge_seen;
        logic [htach_pkg::RPM_W-1:0]   pass_rpm;
        logic [htach_pkg::RPM_W-1:0]   average_rpm;
        logic [htach_pkg::SPEED_W-1:0] speed_kmh;
        logic                          broadcast;
    } t_tach_result;

    // Receiver behavior modes, each picked at random by the receiver.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_DENSE
    } t_rx_mode;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_wr_en = 1'b0;
    logic [htach_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [htach_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                             i_valid = 1'b0;
    logic                             o_ready;
    logic [htach_pkg::SAMPLE_W-1:0]   i_sample = '0;
    logic [htach_pkg::TIME_W-1:0]     i_now_ms = '0;
    logic                             o_valid;
    logic                             i_ready = 1'b0;
    logic                             o_edge_seen;
    logic [htach_pkg::RPM_W-1:0]      o_pass_rpm;
    logic [htach_pkg::RPM_W-1:0]      o_average_rpm;
    logic [htach_pkg::SPEED_W-1:0]    o_speed_kmh;
    logic                             o_broadcast;

    hall_tachometer_with_stop_detect dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .i_now_ms      (i_now_ms),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_edge_seen   (o_edge_seen),
        .o_pass_rpm    (o_pass_rpm),
        .o_average_rpm (o_average_rpm),
        .o_speed_kmh   (o_speed_kmh),
        .o_broadcast   (o_broadcast)
    );

    // Polls waiting to be offered, and the results owed for polls taken.
    t_poll        polls_pending[$];
    t_tach_result results_due[$];
    int           fail_count = 0;
    int           result_count = 0;
    logic [htach_pkg::TIME_W-1:0] t_now = '0;

    // Shadow copy of the register file.
    logic [7:0]  cfg_hyst;
    logic [7:0]  cfg_mags;
    logic [15:0] cfg_max_int;
    logic [15:0] cfg_period;
    logic [7:0]  cfg_stop;
    logic [15:0] cfg_factor;

    // Shadow copy of the tachometer state.
    logic                            m_sensor_high;
    logic [htach_pkg::TIME_W-1:0]    m_last_high;
    logic [htach_pkg::TIME_W-1:0]    m_last_low;
    logic [htach_pkg::RPM_W-1:0]     m_ring [htach_pkg::AVG_DEPTH];
    logic [htach_pkg::AVG_IDX_W-1:0] m_ring_idx;
    logic [htach_pkg::SUM_W-1:0]     m_ring_sum;
    logic [15:0]                     m_passes;
    logic [7:0]                      m_idle;
    logic [htach_pkg::TIME_W-1:0]    m_period_start;
    logic [htach_pkg::RPM_W-1:0]     m_last_pass;

    // Driver pacing.
    int burst_left;
    int gap_left;

    // Receiver pacing.
    int       rx_tick;
    int       hold_left;
    t_rx_mode rx_mode;

    int cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Replace the oldest ring slot and keep the running sum in step.
    function automatic void ring_push(logic [htach_pkg::RPM_W-1:0] rpm);
        m_ring_sum = m_ring_sum - htach_pkg::SUM_W'(m_ring[m_ring_idx])
                     + htach_pkg::SUM_W'(rpm);
        m_ring[m_ring_idx] = rpm;
        m_ring_idx = m_ring_idx + 1'b1;
    endfunction

    // Single-pass rpm: zero interval counts as 1 ms, zero magnets as one,
    // and anything slower than the max interval reads as standstill.
    function automatic logic [htach_pkg::RPM_W-1:0] rpm_of_interval(
            logic [htach_pkg::TIME_W-1:0] interval);
        logic [31:0] mags;
        logic [31:0] ivl;
        mags = (cfg_mags == 8'd0) ? 32'd1 : 32'(cfg_mags);
        ivl  = (interval == '0) ? 32'd1 : interval;
        if (ivl > 32'(cfg_max_int))
            return '0;
        return htach_pkg::RPM_W'(32'(htach_pkg::RPM_NUMERATOR) / (ivl * mags));
    endfunction

    // Advance the shadow state by one poll and return the result it owes.
    function automatic t_tach_result predict_tach(t_poll p);
        t_tach_result r;
        logic [htach_pkg::TIME_W-1:0] elapsed;
        int unsigned lo_th;
        int unsigned hi_th;
        logic [31:0] scaled;
        r = '0;

        // Stop check: an empty period counts up, then pushes zeros.
        elapsed = p.now_ms - m_period_start;
        if (elapsed >= 32'(cfg_period)) begin
            if (m_passes == 16'd0) begin
                if (m_idle < cfg_stop)
                    m_idle = m_idle + 8'd1;
                else
                    ring_push('0);
            end else begin
                m_idle = 8'd0;
            end
            m_passes = 16'd0;
            m_period_start = p.now_ms;
            r.broadcast = 1'b1;
        end

        // Hysteresis around the midpoint; an edge times the opposite edge.
        lo_th = int'(htach_pkg::MIDPOINT) - int'(cfg_hyst);
        hi_th = int'(htach_pkg::MIDPOINT) + int'(cfg_hyst);
        if (m_sensor_high) begin
            if (p.sample < lo_th) begin
                m_sensor_high = 1'b0;
                m_last_low = p.now_ms;
                m_last_pass = rpm_of_interval(p.now_ms - m_last_high);
                r.edge_seen = 1'b1;
            end
        end else begin
            if (p.sample > hi_th) begin
                m_sensor_high = 1'b1;
                m_last_high = p.now_ms;
                m_last_pass = rpm_of_interval(p.now_ms - m_last_low);
                r.edge_seen = 1'b1;
            end
        end
        if (r.edge_seen) begin
            if (m_passes != 16'hFFFF)
                m_passes = m_passes + 16'd1;
            m_idle = 8'd0;
            ring_push(m_last_pass);
        end

        r.pass_rpm = m_last_pass;
        r.average_rpm = htach_pkg::RPM_W'(m_ring_sum / htach_pkg::AVG_DEPTH);
        scaled = 32'(r.average_rpm) * 32'(cfg_factor);
        r.speed_kmh = (scaled[31:16] > 16'd255) ? htach_pkg::SPEED_MAX : scaled[23:16];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Configuration and stimulus helpers
    // ------------------------------------------------------------------

    // Write one register and mirror it; indexes past the list are dropped.
    task automatic write_reg(input logic [htach_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            htach_pkg::REG_HYSTERESIS:   cfg_hyst    = val[7:0];
            htach_pkg::REG_MAGNET_COUNT: cfg_mags    = val[7:0];
            htach_pkg::REG_MAX_INTERVAL: cfg_max_int = val;
            htach_pkg::REG_BCAST_PERIOD: cfg_period  = val;
            htach_pkg::REG_STOP_PERIODS: cfg_stop    = val[7:0];
            htach_pkg::REG_SPEED_FACTOR: cfg_factor  = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] hyst, input logic [7:0] mags,
                              input logic [15:0] max_int, input logic [15:0] period,
                              input logic [7:0] stop, input logic [15:0] factor);
        write_reg(htach_pkg::REG_HYSTERESIS, 16'(hyst));
        write_reg(htach_pkg::REG_MAGNET_COUNT, 16'(mags));
        write_reg(htach_pkg::REG_MAX_INTERVAL, max_int);
        write_reg(htach_pkg::REG_BCAST_PERIOD, period);
        write_reg(htach_pkg::REG_STOP_PERIODS, 16'(stop));
        write_reg(htach_pkg::REG_SPEED_FACTOR, factor);
        @(negedge i_clk);
    endtask

    task automatic queue_poll(input logic [htach_pkg::SAMPLE_W-1:0] s,
                              input logic [htach_pkg::TIME_W-1:0] t);
        t_poll p;
        p.sample = s;
        p.now_ms = t;
        polls_pending.push_back(p);
    endtask

    // Build runs of wheel behavior: mostly spinning with alternating
    // polarity, some standstill inside the dead band, some raw noise.
    task automatic queue_wheel_polls(input int n);
        int left;
        int run;
        int style;
        int step_max;
        int h;
        int per;
        logic above;
        logic [htach_pkg::SAMPLE_W-1:0] s;
        left = n;
        above = 1'b0;
        while (left > 0) begin
            h = int'(cfg_hyst);
            per = int'(cfg_period);
            style = $urandom_range(0, 9);
            run = $urandom_range(4, 40);
            if (run > left)
                run = left;
            case ($urandom_range(0, 3))
                0: step_max = 1;
                1: step_max = 6;
                2: step_max = 25;
                default: step_max = 90;
            endcase
            for (int k = 0; k < run; k++) begin
                if (style < 6) begin
                    if ($urandom_range(0, 3) == 0) begin
                        s = htach_pkg::SAMPLE_W'($urandom_range(512 - h, 512 + h));
                    end else begin
                        if ($urandom_range(0, 3) != 0)
                            above = !above;
                        s = above ? htach_pkg::SAMPLE_W'($urandom_range(513 + h, 1023))
                                  : htach_pkg::SAMPLE_W'($urandom_range(0, 511 - h));
                    end
                    t_now = t_now + $urandom_range(0, step_max);
                end else if (style < 8) begin
                    s = htach_pkg::SAMPLE_W'($urandom_range(512 - h, 512 + h));
                    t_now = t_now + $urandom_range(per / 2, 2 * per);
                end else begin
                    s = htach_pkg::SAMPLE_W'($urandom_range(0, 1023));
                    if ($urandom_range(0, 7) == 0)
                        t_now = t_now + $urandom();
                    else
                        t_now = t_now + $urandom_range(0, 1000);
                end
                queue_poll(s, t_now);
            end
            left -= run;
        end
    endtask

    // Block until every queued poll is taken and every result is back.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (polls_pending.size() != 0 || i_valid || results_due.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Driver: offer polls in bursts, predict on each accepted item
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_polls
        t_poll taken;
        t_poll next_poll;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            // Predict from the payload on the bus at the accepting edge.
            if (i_valid && o_ready) begin
                taken.sample = i_sample;
                taken.now_ms = i_now_ms;
                results_due.push_back(predict_tach(taken));
            end
            // Hold the payload while the item waits; otherwise refill or idle.
            if (!i_valid || o_ready) begin
                if (gap_left > 0 || polls_pending.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    i_valid <= 1'b0;
                end else begin
                    next_poll = polls_pending.pop_front();
                    i_valid  <= 1'b1;
                    i_sample <= next_poll.sample;
                    i_now_ms <= next_poll.now_ms;
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 16);
                    burst_left--;
                    // Drop back to idle after a burst, but often run straight on.
                    if (burst_left == 0)
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern plus two long hold-offs that back up the input
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_tick = 0;
            hold_left = 0;
            rx_mode = RX_OPEN;
        end else begin
            rx_tick++;
            if (rx_tick == 4000 || rx_tick == 15000)
                hold_left = 400;
            if (rx_tick % 48 == 0)
                rx_mode = t_rx_mode'($urandom_range(0, 3));
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:   i_ready <= 1'b1;
                    RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest one owed
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_tach_result got;
        t_tach_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got.edge_seen   = o_edge_seen;
            got.pass_rpm    = o_pass_rpm;
            got.average_rpm = o_average_rpm;
            got.speed_kmh   = o_speed_kmh;
            got.broadcast   = o_broadcast;
            result_count++;
            if (results_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("result %0d with no poll outstanding: edge=%0b pass=%0d avg=%0d",
                             result_count, got.edge_seen, got.pass_rpm, got.average_rpm);
            end else begin
                want = results_due.pop_front();
                if (got.edge_seen !== want.edge_seen || got.pass_rpm !== want.pass_rpm ||
                    got.average_rpm !== want.average_rpm ||
                    got.speed_kmh !== want.speed_kmh || got.broadcast !== want.broadcast) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"result %0d mismatch: expected edge=%0b pass=%0d avg=%0d ",
                                  "speed=%0d bcast=%0b, got edge=%0b pass=%0d avg=%0d ",
                                  "speed=%0d bcast=%0b"}, result_count,
                                 want.edge_seen, want.pass_rpm, want.average_rpm,
                                 want.speed_kmh, want.broadcast,
                                 got.edge_seen, got.pass_rpm, got.average_rpm,
                                 got.speed_kmh, got.broadcast);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, directed polls, then configuration phases
    // ------------------------------------------------------------------
    initial begin
        // Mirror the reset values.
        cfg_hyst    = htach_pkg::RST_HYSTERESIS;
        cfg_mags    = htach_pkg::RST_MAGNET_COUNT;
        cfg_max_int = htach_pkg::RST_MAX_INTERVAL;
        cfg_period  = htach_pkg::RST_BCAST_PERIOD;
        cfg_stop    = htach_pkg::RST_STOP_PERIODS;
        cfg_factor  = htach_pkg::RST_SPEED_FACTOR;
        m_sensor_high  = 1'b0;
        m_last_high    = '0;
        m_last_low     = '0;
        m_ring_idx     = '0;
        m_ring_sum     = '0;
        m_passes       = '0;
        m_idle         = '0;
        m_period_start = '0;
        m_last_pass    = '0;
        for (int i = 0; i < htach_pkg::AVG_DEPTH; i++)
            m_ring[i] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed polls at the reset configuration.
        queue_poll(10'd512, 32'd0);        // midpoint, no pass
        queue_poll(10'd533, 32'd0);        // rising pass with zero interval
        queue_poll(10'd492, 32'd5);        // exactly on the low threshold: hold
        queue_poll(10'd491, 32'd10);       // falling pass
        queue_poll(10'd1023, 32'd20);      // top of the range
        queue_poll(10'd0, 32'd30);         // bottom of the range
        queue_poll(10'd1023, 32'd400);     // interval beyond max: rpm reads zero
        // Standstill long enough to run the idle count out and push zeros.
        for (int k = 0; k < 14; k++)
            queue_poll(10'd512, 32'(450 + 50 * k));
        // Timestamps wrap through zero.
        queue_poll(10'd0, 32'hFFFF_FFF0);
        queue_poll(10'd1023, 32'h0000_0005);
        queue_poll(10'd532, 32'h0000_0006);
        queue_poll(10'd492, 32'h0000_0007);
        wait_drained();

        // Low extremes of the sensing, high extremes of the scaling.
        t_now = 32'h0000_1000;
        set_config(8'd10, 8'd1, 16'd65535, 16'd1, 8'd1, 16'd65535);
        queue_wheel_polls(150);
        wait_drained();

        // Opposite corner: widest legal band, most magnets, slowest periods.
        set_config(8'd128, 8'd255, 16'd1, 16'd65535, 8'd255, 16'd0);
        queue_wheel_polls(100);
        wait_drained();

        // Band past the legal range, zero magnets, short stop limit.
        t_now = 32'hFFFF_F000;
        set_config(8'd255, 8'd0, 16'd300, 16'd20, 8'd3, 16'd1359);
        queue_wheel_polls(150);
        wait_drained();

        // Drop the stop limit below the idle count already reached, and
        // collapse the band to zero through a write with upper bits set.
        write_reg(htach_pkg::REG_STOP_PERIODS, 16'd0);
        write_reg(htach_pkg::REG_HYSTERESIS, 16'h3F00);
        @(negedge i_clk);
        queue_wheel_polls(120);
        wait_drained();

        // Writes to unused slots must leave the registers alone.
        write_reg(REG_SPARE_6, 16'h1234);
        write_reg(REG_SPARE_7, 16'hFFFF);
        @(negedge i_clk);
        queue_wheel_polls(50);
        wait_drained();

        // Random settings in the working range.
        for (int ph = 0; ph < 6; ph++) begin
            if (ph % 2 == 0)
                t_now = $urandom();
            set_config(8'($urandom_range(10, 128)), 8'($urandom_range(1, 16)),
                       16'($urandom_range(20, 2000)), 16'($urandom_range(1, 150)),
                       8'($urandom_range(1, 12)), 16'($urandom_range(0, 65535)));
            queue_wheel_polls(110);
            wait_drained();
        end

        // Let any stray result surface before the verdict.
        repeat (40) @(negedge i_clk);
        if (fail_count == 0 && results_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
